@@ sv/rrac_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the rounded rectangle alpha compositor
package rrac_pkg;

	localparam int COORD_W  = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_ALPHA    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_OR_MASK = 4'd7;

	localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
	localparam logic [7:0]  ALPHA_CLEAR    = 8'h00;
	localparam logic [7:0]  FILL_ALPHA_RST = 8'hFF;
	localparam logic [31:0] OR_MASK_RST    = 32'hFF00_0000;

	typedef struct packed {
		logic signed [12:0] rect_left;
		logic signed [12:0] rect_top;
		logic [12:0]        rect_width;
		logic [12:0]        rect_height;
		logic [31:0]        fill_color;
		logic [7:0]         fill_alpha;
		logic [7:0]         corner_radius;
		logic [31:0]        color_or_mask;
	} cfg_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

endpackage

@@ sv/rrac_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration register file with write channel
module rrac_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rrac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrac_pkg::CFG_DATA_W-1:0]     cfg_data,
	output rrac_pkg::cfg_t                      cfg
);
	import rrac_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rect_left     <= '0;
			cfg_q.rect_top      <= '0;
			cfg_q.rect_width    <= '0;
			cfg_q.rect_height   <= '0;
			cfg_q.fill_color    <= '0;
			cfg_q.fill_alpha    <= FILL_ALPHA_RST;
			cfg_q.corner_radius <= '0;
			cfg_q.color_or_mask <= OR_MASK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RECT_LEFT:     cfg_q.rect_left     <= signed'(cfg_data[12:0]);
				REG_RECT_TOP:      cfg_q.rect_top      <= signed'(cfg_data[12:0]);
				REG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_data[12:0];
				REG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_data[12:0];
				REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_data[31:0];
				REG_FILL_ALPHA:    cfg_q.fill_alpha    <= cfg_data[7:0];
				REG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_data[7:0];
				REG_COLOR_OR_MASK: cfg_q.color_or_mask <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

endmodule

@@ sv/rrac_geom.sv @@
`timescale 1ns / 1ps
// geometry pipeline: rectangle test, corner pick and squared distances
module rrac_geom #(
	parameter int unsigned SCREEN_MAX = 4096
) (
	input  logic                clk,
	input  rrac_pkg::pipe_en_t  en,
	input  rrac_pkg::cfg_t      cfg,
	input  logic [11:0]         pixel_x,
	input  logic [11:0]         pixel_y,
	output logic                inside_s3,
	output logic                hit_s3,
	output logic [15:0]         dxx_s3,
	output logic [15:0]         dyy_s3,
	output logic [15:0]         rr_s3
);
	import rrac_pkg::*;

	localparam logic [16:0] SCREEN_LIM = 17'(SCREEN_MAX);

	logic signed [COORD_W-1:0] x_w, y_w, left_w, top_w, right_w, bottom_w;
	logic                      inside_c;
	logic signed [COORD_W-1:0] lx_s1, ly_s1, rx_s1, ry_s1;
	logic                      inside_s1;

	logic signed [COORD_W-1:0] rad_w;
	logic                      hit_c;
	logic [7:0]                hd_c, vd_c;
	logic                      inside_s2, hit_s2;
	logic [7:0]                dx_s2, dy_s2;

	assign x_w      = signed'({4'd0, pixel_x});
	assign y_w      = signed'({4'd0, pixel_y});
	assign left_w   = {{3{cfg.rect_left[12]}}, cfg.rect_left};
	assign top_w    = {{3{cfg.rect_top[12]}}, cfg.rect_top};
	assign right_w  = left_w + signed'({3'd0, cfg.rect_width});
	assign bottom_w = top_w + signed'({3'd0, cfg.rect_height});

	assign inside_c = ({5'd0, pixel_x} < SCREEN_LIM) && ({5'd0, pixel_y} < SCREEN_LIM) &&
		(x_w >= left_w) && (x_w < right_w) && (y_w >= top_w) && (y_w < bottom_w);

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			inside_s1 <= inside_c;
			lx_s1     <= x_w - left_w;
			ly_s1     <= y_w - top_w;
			rx_s1     <= right_w - 16'sd1 - x_w;
			ry_s1     <= bottom_w - 16'sd1 - y_w;
		end
	end

	// corners in order top-left, top-right, bottom-left, bottom-right
	assign rad_w = signed'({8'd0, cfg.corner_radius});

	always_comb begin
		hit_c = 1'b0;
		hd_c  = '0;
		vd_c  = '0;
		if (lx_s1 < rad_w && ly_s1 < rad_w) begin
			hit_c = 1'b1;
			hd_c  = lx_s1[7:0];
			vd_c  = ly_s1[7:0];
		end else if (rx_s1 < rad_w && ly_s1 < rad_w) begin
			hit_c = 1'b1;
			hd_c  = rx_s1[7:0];
			vd_c  = ly_s1[7:0];
		end else if (lx_s1 < rad_w && ry_s1 < rad_w) begin
			hit_c = 1'b1;
			hd_c  = lx_s1[7:0];
			vd_c  = ry_s1[7:0];
		end else if (rx_s1 < rad_w && ry_s1 < rad_w) begin
			hit_c = 1'b1;
			hd_c  = rx_s1[7:0];
			vd_c  = ry_s1[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			inside_s2 <= inside_s1;
			hit_s2    <= hit_c;
			dx_s2     <= cfg.corner_radius - hd_c - 8'd1;
			dy_s2     <= cfg.corner_radius - vd_c - 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			inside_s3 <= inside_s2;
			hit_s3    <= hit_s2;
			dxx_s3    <= dx_s2 * dx_s2;
			dyy_s3    <= dy_s2 * dy_s2;
			rr_s3     <= cfg.corner_radius * cfg.corner_radius;
		end
	end

endmodule

@@ sv/rrac_blend.sv @@
`timescale 1ns / 1ps
// color pipeline: per-channel alpha products and mixed word
module rrac_blend (
	input  logic                clk,
	input  rrac_pkg::pipe_en_t  en,
	input  rrac_pkg::cfg_t      cfg,
	input  logic [31:0]         dest_pixel,
	output logic [31:0]         dest_s3,
	output logic [31:0]         mix_s3
);
	import rrac_pkg::*;

	logic [31:0] dest_s1, dest_s2;
	logic [7:0]  ia;
	logic [15:0] sp_s2 [3];
	logic [15:0] dp_s2 [3];
	logic [15:0] sum_c [3];
	logic [23:0] rgb_c;

	assign ia = ALPHA_OPAQUE - cfg.fill_alpha;

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			dest_s1 <= dest_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			dest_s2 <= dest_s1;
			for (int c = 0; c < 3; c++) begin
				sp_s2[c] <= cfg.fill_color[c*8 +: 8] * cfg.fill_alpha;
				dp_s2[c] <= dest_s1[c*8 +: 8] * ia;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c]       = sp_s2[c] + dp_s2[c];
			rgb_c[c*8 +: 8] = sum_c[c][15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			dest_s3 <= dest_s2;
			if (cfg.fill_alpha == ALPHA_OPAQUE) begin
				mix_s3 <= cfg.fill_color;
			end else if (cfg.fill_alpha == ALPHA_CLEAR) begin
				mix_s3 <= dest_s2;
			end else begin
				mix_s3 <= cfg.color_or_mask | {8'd0, rgb_c};
			end
		end
	end

endmodule

@@ sv/rounded_rect_alpha_compositor_unit.sv @@
`timescale 1ns / 1ps
// top level: rounded rectangle alpha compositor with stream ports
// Takes one pixel per clock while s_tready is high and returns one pixel per
// input, in order; the result reaches the master side through a four-stage
// register pipeline (rectangle test, corner pick and products, squares and
// sums, final select). Backpressure on m_tready stalls a stage holding data
// only when every stage after it is full too; empty stages still fill, so
// s_tready stays high while bubbles remain. Configuration writes are taken on
// every cycle and should only be issued while no pixel is in flight.
module rounded_rect_alpha_compositor_unit #(
	parameter int unsigned SCREEN_MAX = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rrac_pkg::IN_DATA_W-1:0]      s_tdata,  // pixel_x, pixel_y, dest_pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rrac_pkg::OUT_DATA_W-1:0]     m_tdata,  // out_pixel
	output logic [0:0]                          m_tuser,  // written
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rrac_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrac_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rrac_pkg::*;

	cfg_t        cfg;
	pipe_en_t    en;
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        inside_s3, hit_s3;
	logic [15:0] dxx_s3, dyy_s3, rr_s3;
	logic [31:0] dest_s3, mix_s3;
	logic [16:0] dist_c;
	logic        written_c;
	logic        written_s4;
	logic [31:0] out_pixel_s4;

	rrac_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign en.en_s4 = !valid_s4 || m_tready;
	assign en.en_s3 = !valid_s3 || en.en_s4;
	assign en.en_s2 = !valid_s2 || en.en_s3;
	assign en.en_s1 = !valid_s1 || en.en_s2;
	assign s_tready = en.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en.en_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	rrac_geom #(
		.SCREEN_MAX (SCREEN_MAX)
	) u_geom (
		.clk       (clk),
		.en        (en),
		.cfg       (cfg),
		.pixel_x   (s_tdata[11:0]),
		.pixel_y   (s_tdata[23:12]),
		.inside_s3 (inside_s3),
		.hit_s3    (hit_s3),
		.dxx_s3    (dxx_s3),
		.dyy_s3    (dyy_s3),
		.rr_s3     (rr_s3)
	);

	rrac_blend u_blend (
		.clk        (clk),
		.en         (en),
		.cfg        (cfg),
		.dest_pixel (s_tdata[55:24]),
		.dest_s3    (dest_s3),
		.mix_s3     (mix_s3)
	);

	assign dist_c    = {1'b0, dxx_s3} + {1'b0, dyy_s3};
	assign written_c = inside_s3 && !(hit_s3 && (dist_c > {1'b0, rr_s3}));

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			written_s4   <= written_c;
			out_pixel_s4 <= written_c ? mix_s3 : dest_s3;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = out_pixel_s4;
	assign m_tuser  = written_s4;

endmodule

@@ dv/rrac_checker.sv @@
`timescale 1ns / 1ps
// checker: predicts each composited pixel from the observed traffic and compares the output stream
module rrac_checker #(
	parameter int unsigned SCREEN_MAX = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rrac_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rrac_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rrac_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrac_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              fail_count,
	output int                              pending_count
);
	import rrac_pkg::*;

	typedef struct {
		logic [31:0] pixel;
		logic        written;
	} pixel_result_t;

	pixel_result_t expected_pixels[$];
	cfg_t          cfg_regs;

	function automatic logic [31:0] blend_fill(input cfg_t c, input logic [31:0] dst);
		logic [31:0] rgb;
		int unsigned s, d, a;
		if (c.fill_alpha == ALPHA_OPAQUE)
			return c.fill_color;
		if (c.fill_alpha == ALPHA_CLEAR)
			return dst;
		rgb = '0;
		a = c.fill_alpha;
		for (int i = 0; i < 3; i++) begin
			s = c.fill_color[8*i +: 8];
			d = dst[8*i +: 8];
			rgb[8*i +: 8] = 8'((s * a + d * (ALPHA_OPAQUE - a)) >> 8);
		end
		// old alpha byte is dropped, mask supplies the top byte
		return c.color_or_mask | rgb;
	endfunction

	function automatic pixel_result_t composite_pixel(input cfg_t c, input logic [11:0] x,
			input logic [11:0] y, input logic [31:0] dst);
		pixel_result_t r;
		longint px, py, left, top, w, h, rad, lx, ly, rx, ry, hd, vd, dx, dy;
		logic in_rect, corner_hit, cut;
		px = x;
		py = y;
		left = c.rect_left;
		top = c.rect_top;
		w = c.rect_width;
		h = c.rect_height;
		rad = c.corner_radius;
		hd = 0;
		vd = 0;
		corner_hit = 1'b0;
		cut = 1'b0;
		in_rect = px < longint'(SCREEN_MAX) && py < longint'(SCREEN_MAX) &&
			px >= left && px < left + w && py >= top && py < top + h;
		if (in_rect) begin
			lx = px - left;
			ly = py - top;
			rx = left + w - 1 - px;
			ry = top + h - 1 - py;
			// first matching corner wins when corners overlap
			if (lx < rad && ly < rad) begin
				hd = lx; vd = ly; corner_hit = 1'b1;
			end else if (rx < rad && ly < rad) begin
				hd = rx; vd = ly; corner_hit = 1'b1;
			end else if (lx < rad && ry < rad) begin
				hd = lx; vd = ry; corner_hit = 1'b1;
			end else if (rx < rad && ry < rad) begin
				hd = rx; vd = ry; corner_hit = 1'b1;
			end
			if (corner_hit) begin
				dx = rad - hd - 1;
				dy = rad - vd - 1;
				cut = dx * dx + dy * dy > rad * rad;
			end
		end
		if (in_rect && !cut) begin
			r.pixel = blend_fill(c, dst);
			r.written = 1'b1;
		end else begin
			r.pixel = dst;
			r.written = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		pixel_result_t want;
		if (!arst_n) begin
			cfg_regs = '{rect_left: '0, rect_top: '0, rect_width: '0, rect_height: '0,
				fill_color: '0, fill_alpha: FILL_ALPHA_RST, corner_radius: '0,
				color_or_mask: OR_MASK_RST};
			expected_pixels.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RECT_LEFT:     cfg_regs.rect_left = cfg_data[12:0];
					REG_RECT_TOP:      cfg_regs.rect_top = cfg_data[12:0];
					REG_RECT_WIDTH:    cfg_regs.rect_width = cfg_data[12:0];
					REG_RECT_HEIGHT:   cfg_regs.rect_height = cfg_data[12:0];
					REG_FILL_COLOR:    cfg_regs.fill_color = cfg_data;
					REG_FILL_ALPHA:    cfg_regs.fill_alpha = cfg_data[7:0];
					REG_CORNER_RADIUS: cfg_regs.corner_radius = cfg_data[7:0];
					REG_COLOR_OR_MASK: cfg_regs.color_or_mask = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("output transaction with nothing expected: out_pixel %h written %b",
						m_tdata, m_tuser[0]);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_tdata !== want.pixel) begin
						$error("out_pixel mismatch: expected %h, actual %h", want.pixel, m_tdata);
						fail_count++;
					end
					if (m_tuser[0] !== want.written) begin
						$error("written mismatch: expected %b, actual %b", want.written, m_tuser[0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(composite_pixel(cfg_regs, s_tdata[11:0],
					s_tdata[23:12], s_tdata[55:24]));
		end
		pending_count = expected_pixels.size();
	end

endmodule

@@ dv/rounded_rect_alpha_compositor_unit_tb.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, pixel and register stimulus, watchdog and verdict
module rounded_rect_alpha_compositor_unit_tb;
	import rrac_pkg::*;

	localparam int unsigned SCREEN_MAX = 4096;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_SETS = 14;
	localparam int PIXELS_PER_SET = 125;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending_count;
	int                    send_idle_pct = 35;
	int                    recv_idle_pct = 57;
	int                    stall_cycles = 0;

	always #1 clk = ~clk;

	rounded_rect_alpha_compositor_unit #(.SCREEN_MAX(SCREEN_MAX)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rrac_checker #(.SCREEN_MAX(SCREEN_MAX)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic [31:0] dst);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {dst, y, x};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		wait_idle();
		// an index past the register list is ignored by the block
		if ($urandom_range(1))
			write_reg(REG_COLOR_OR_MASK + 4'd1 + 4'($urandom_range(7)), $urandom);
		write_reg(REG_RECT_LEFT, 32'(c.rect_left));
		write_reg(REG_RECT_TOP, 32'(c.rect_top));
		write_reg(REG_RECT_WIDTH, 32'(c.rect_width));
		write_reg(REG_RECT_HEIGHT, 32'(c.rect_height));
		write_reg(REG_FILL_COLOR, c.fill_color);
		write_reg(REG_FILL_ALPHA, 32'(c.fill_alpha));
		write_reg(REG_CORNER_RADIUS, 32'(c.corner_radius));
		write_reg(REG_COLOR_OR_MASK, c.color_or_mask);
		cfg_valid <= 1'b0;
	endtask

	function automatic int pick_value(input int lo, input int hi, input int near_lo,
			input int near_hi);
		case ($urandom_range(7))
			0: return lo;
			1: return hi;
			2, 3: return lo + int'($urandom_range(hi - lo));
			default: return near_lo + int'($urandom_range(near_hi - near_lo));
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.rect_left = 13'(pick_value(-4096, 4095, -40, 200));
		c.rect_top = 13'(pick_value(-4096, 4095, -40, 200));
		c.rect_width = 13'(pick_value(0, 4096, 0, 120));
		c.rect_height = 13'(pick_value(0, 4096, 0, 120));
		c.fill_color = pick_word();
		c.fill_alpha = 8'(pick_value(0, 255, 1, 254));
		c.corner_radius = 8'(pick_value(0, 255, 0, 40));
		c.color_or_mask = pick_word();
		return c;
	endfunction

	// coordinates bunched around the rectangle edges so corners get exercised
	function automatic logic [11:0] near_coord(input int base, input int span, input int rad);
		int v;
		case ($urandom_range(9))
			0, 1, 2: return 12'($urandom);
			3, 4, 5: v = base - 2 + int'($urandom_range(rad + 3));
			6, 7: v = base + span + 1 - int'($urandom_range(rad + 3));
			default: v = base - 2 + int'($urandom_range(span + 3));
		endcase
		if (v < 0 || v > 4095)
			v = $urandom_range(4095);
		return v[11:0];
	endfunction

	initial begin
		cfg_t c;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// reset values: empty rectangle, every pixel passes through
		send_pixel(12'd0, 12'd0, 32'h0000_0000);
		send_pixel(12'd4095, 12'd4095, 32'hFFFF_FFFF);

		// partial alpha with rounded corners
		c = '{rect_left: 13'sd10, rect_top: 13'sd20, rect_width: 13'd40, rect_height: 13'd30,
			fill_color: 32'h80C0_4020, fill_alpha: 8'h80, corner_radius: 8'd8,
			color_or_mask: 32'h5A00_0001};
		program_regs(c);
		send_pixel(12'd10, 12'd20, 32'hFFFF_FFFF);
		send_pixel(12'd17, 12'd27, 32'h0000_0000);
		send_pixel(12'd49, 12'd20, $urandom);
		send_pixel(12'd10, 12'd49, $urandom);
		send_pixel(12'd49, 12'd49, $urandom);
		send_pixel(12'd30, 12'd35, 32'hFFFF_FFFF);
		send_pixel(12'd9, 12'd35, $urandom);
		send_pixel(12'd50, 12'd35, $urandom);
		send_pixel(12'd30, 12'd19, $urandom);
		send_pixel(12'd30, 12'd50, $urandom);
		send_pixel(12'd12, 12'd21, $urandom);

		// opaque fill, rectangle running past the screen edge
		c = '{rect_left: 13'sd4000, rect_top: 13'sd4000, rect_width: 13'd4096,
			rect_height: 13'd4096, fill_color: 32'hFFFF_FFFF, fill_alpha: ALPHA_OPAQUE,
			corner_radius: 8'd0, color_or_mask: 32'h0000_0000};
		program_regs(c);
		send_pixel(12'd4095, 12'd4095, $urandom);
		send_pixel(12'd3999, 12'd4000, $urandom);
		send_pixel(12'd4000, 12'd4000, $urandom);

		// transparent fill, rectangle starting off screen, largest radius
		c = '{rect_left: -13'sd100, rect_top: -13'sd100, rect_width: 13'd4096,
			rect_height: 13'd4096, fill_color: 32'h1234_5678, fill_alpha: ALPHA_CLEAR,
			corner_radius: 8'd255, color_or_mask: 32'hFFFF_FFFF};
		program_regs(c);
		send_pixel(12'd0, 12'd0, $urandom);
		send_pixel(12'd4095, 12'd4095, $urandom);
		send_pixel(12'd3995, 12'd3995, $urandom);

		// tiny rectangle where the corners overlap
		c = '{rect_left: 13'sd100, rect_top: 13'sd100, rect_width: 13'd5, rect_height: 13'd3,
			fill_color: 32'hA0B0_C0D0, fill_alpha: 8'h40, corner_radius: 8'd4,
			color_or_mask: 32'hFF00_0000};
		program_regs(c);
		send_pixel(12'd100, 12'd100, $urandom);
		send_pixel(12'd102, 12'd101, $urandom);
		send_pixel(12'd104, 12'd102, $urandom);
		send_pixel(12'd101, 12'd101, $urandom);

		for (int k = 0; k < RANDOM_SETS; k++) begin
			if (k == RANDOM_SETS / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 35;
			end else if (k == 2 * RANDOM_SETS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			c = random_cfg();
			program_regs(c);
			for (int n = 0; n < PIXELS_PER_SET; n++)
				send_pixel(near_coord(c.rect_left, c.rect_width, c.corner_radius),
					near_coord(c.rect_top, c.rect_height, c.corner_radius), $urandom);
		end

		wait_idle();
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ rounded_rect_alpha_compositor_unit.f @@
sv/rrac_pkg.sv
sv/rrac_cfg_regs.sv
sv/rrac_geom.sv
sv/rrac_blend.sv
sv/rounded_rect_alpha_compositor_unit.sv
dv/rrac_checker.sv
dv/rounded_rect_alpha_compositor_unit_tb.sv
